// ===== rtl/core/entity_table_lookup_alloc_macros.svh =====
// assertion macros for the checker file of the entity table
// expects clk and rst_n in the scope where a macro is used
`ifndef ENTITY_TABLE_LOOKUP_ALLOC_MACROS_SVH
`define ENTITY_TABLE_LOOKUP_ALLOC_MACROS_SVH

// same-cycle implication, checked outside reset
`define ETL_ASSERT_NOW(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ETL_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/core/etl_pkg.sv =====
// package for the entity table: sizes, codes, entry and struct types
// no dependencies
package etl_pkg;

    localparam int ENTRIES  = 256;
    localparam int PROFILES = 6;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int TOTAL_W  = 9;
    localparam int SLOT_W   = 8;
    localparam int ID_W     = 24;
    localparam int PROF_W   = 3;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_ALLOC  = 2'd1,
        CMD_WRITE  = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_BAD       = 3'd4,
        ST_WRITTEN   = 3'd5,
        ST_CLEARED   = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRD,
        S_WRU,
        S_RESP
    } state_t;

    // one table entry: profile in the top bits, then type, then id
    typedef struct packed {
        logic [PROF_W-1:0] profile;
        logic              etype;
        logic [ID_W-1:0]   id;
    } entry_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
        logic             clear_all;
    } mem_req_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } mem_rsp_t;

    typedef struct packed {
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic [PROF_W-1:0]  profile;
        logic [TOTAL_W-1:0] indiv;
        logic [TOTAL_W-1:0] group;
    } res_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // slot_index field to table index
    function automatic logic [IDX_W-1:0] to_idx(input logic [SLOT_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[IDX_W-1:0];
    endfunction

    // table index to slot field, low bits only
    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[SLOT_W-1:0];
    endfunction

endpackage

// ===== rtl/core/etl_if.sv =====
// command and response channel interfaces of the entity table
// no dependencies
interface etl_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [23:0] ent_id;
    logic        ent_kind;
    logic [2:0]  prof_num;
    logic [7:0]  slot_index;

    modport source (
        output valid, command, ent_id, ent_kind, prof_num, slot_index,
        input  ready
    );
    modport sink (
        input  valid, command, ent_id, ent_kind, prof_num, slot_index,
        output ready
    );
endinterface

interface etl_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] slot;
    logic [2:0] entry_profile;
    logic [8:0] individual_total;
    logic [8:0] group_total;

    modport source (
        output valid, status, slot, entry_profile, individual_total, group_total,
        input  ready
    );
    modport sink (
        input  valid, status, slot, entry_profile, individual_total, group_total,
        output ready
    );
endinterface

// ===== rtl/core/etl_store.sv =====
// entry memory with one read and one write port, plus per-slot valid bits
// depends on etl_pkg
module etl_store
    import etl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mem_req_t req,
    output mem_rsp_t rsp
);

    entry_t           mem [ENTRIES];
    entry_t           rd_data_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic             rd_valid_reg;
    logic [IDX_W-1:0] rd_addr_reg;

    // entry storage, registered read
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // valid bits and read side tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_addr_reg  <= '0;
        end
        else
        begin
            if (req.clear_all)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
                rd_addr_reg  <= req.rd_addr;
            end
        end
    end

    assign rsp.valid = rd_valid_reg;
    assign rsp.addr  = rd_addr_reg;
    assign rsp.data  = rd_data_reg;

endmodule

// ===== rtl/core/etl_ctrl.sv =====
// command sequencer: table scan, first-free insert, direct write, clear, counts
// depends on etl_pkg, etl_if
module etl_ctrl
    import etl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    etl_cmd_if.sink   cmd,
    output mem_req_t  mem_req,
    input  mem_rsp_t  mem_rsp,
    output logic      res_valid,
    input  logic      res_ready,
    output res_t      res
);

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic               type_reg, type_next;
    logic [PROF_W-1:0]  prof_reg, prof_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   scan_reg, scan_next;
    logic               scan_done_reg, scan_done_next;
    logic               pend_reg, pend_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    status_t            status_reg, status_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [PROF_W-1:0]  rprof_reg, rprof_next;
    logic [TOTAL_W-1:0] indiv_reg, indiv_next;
    logic [TOTAL_W-1:0] group_reg, group_next;

    logic               hit;
    logic               have_free;
    logic [IDX_W-1:0]   fidx;
    logic [TOTAL_W-1:0] inc_i, inc_g, dec_i, dec_g;

    // state and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_done_reg  <= 1'b0;
            pend_reg       <= 1'b0;
            free_found_reg <= 1'b0;
            indiv_reg      <= '0;
            group_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_done_reg  <= scan_done_next;
            pend_reg       <= pend_next;
            free_found_reg <= free_found_next;
            indiv_reg      <= indiv_next;
            group_reg      <= group_next;
        end
    end

    // latched command fields and pending result
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        id_reg       <= id_next;
        type_reg     <= type_next;
        prof_reg     <= prof_next;
        idx_reg      <= idx_next;
        scan_reg     <= scan_next;
        free_idx_reg <= free_idx_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        rprof_reg    <= rprof_next;
    end

    // key match and free slot choice on the entry coming back from memory
    assign hit       = mem_rsp.valid && (mem_rsp.data.etype == type_reg)
                       && (mem_rsp.data.id == id_reg);
    assign have_free = free_found_reg || !mem_rsp.valid;
    assign fidx      = free_found_reg ? free_idx_reg : mem_rsp.addr;

    // count adjust terms for an insert or a direct write
    assign inc_i = TOTAL_W'(!type_reg);
    assign inc_g = TOTAL_W'(type_reg);
    assign dec_i = TOTAL_W'(mem_rsp.valid && !mem_rsp.data.etype);
    assign dec_g = TOTAL_W'(mem_rsp.valid && mem_rsp.data.etype);

    // next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        type_next       = type_reg;
        prof_next       = prof_reg;
        idx_next        = idx_reg;
        scan_next       = scan_reg;
        scan_done_next  = scan_done_reg;
        pend_next       = pend_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        status_next     = status_reg;
        slot_next       = slot_reg;
        rprof_next      = rprof_reg;
        indiv_next      = indiv_reg;
        group_next      = group_reg;
        mem_req         = '0;
        res_valid       = 1'b0;
        cmd.ready       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    cmd_next        = cmd_t'(cmd.command);
                    id_next         = cmd.ent_id;
                    type_next       = cmd.ent_kind;
                    prof_next       = cmd.prof_num;
                    idx_next        = to_idx(cmd.slot_index);
                    scan_next       = '0;
                    scan_done_next  = 1'b0;
                    pend_next       = 1'b0;
                    free_found_next = 1'b0;
                    slot_next       = '0;
                    rprof_next      = '0;
                    case (cmd_t'(cmd.command))
                        CMD_LOOKUP:
                        begin
                            state_next = S_SCAN;
                        end
                        CMD_ALLOC:
                        begin
                            if (32'(cmd.prof_num) >= 32'(PROFILES))
                            begin
                                status_next = ST_BAD;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_WRITE:
                        begin
                            if (32'(cmd.slot_index) >= 32'(ENTRIES)
                                || 32'(cmd.prof_num) >= 32'(PROFILES))
                            begin
                                status_next = ST_BAD;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                state_next = S_WRD;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            mem_req.clear_all = 1'b1;
                            indiv_next        = '0;
                            group_next        = '0;
                            status_next       = ST_CLEARED;
                            state_next        = S_RESP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // issue one read per cycle until the last slot
                if (!scan_done_reg)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = scan_reg;
                    if (scan_reg == LAST_IDX)
                    begin
                        scan_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_next = scan_reg + 1'b1;
                    end
                end
                pend_next = !scan_done_reg;

                // check the entry read in the previous cycle
                if (pend_reg)
                begin
                    if (hit)
                    begin
                        status_next = ST_FOUND;
                        slot_next   = mem_rsp.addr;
                        rprof_next  = mem_rsp.data.profile;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        if (!mem_rsp.valid && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = mem_rsp.addr;
                        end
                        if (mem_rsp.addr == LAST_IDX)
                        begin
                            state_next = S_RESP;
                            if (cmd_reg != CMD_ALLOC)
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                            else if (have_free)
                            begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = fidx;
                                mem_req.wr_data = '{profile: prof_reg, etype: type_reg,
                                                    id: id_reg};
                                indiv_next      = indiv_reg + inc_i;
                                group_next      = group_reg + inc_g;
                                status_next     = ST_INSERTED;
                                slot_next       = fidx;
                                rprof_next      = prof_reg;
                            end
                            else
                            begin
                                status_next = ST_FULL;
                            end
                        end
                    end
                end
            end

            S_WRD:
            begin
                // fetch the old entry to learn its type
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = idx_reg;
                state_next      = S_WRU;
            end

            S_WRU:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg;
                mem_req.wr_data = '{profile: prof_reg, etype: type_reg, id: id_reg};
                indiv_next      = indiv_reg + inc_i - dec_i;
                group_next      = group_reg + inc_g - dec_g;
                status_next     = ST_WRITTEN;
                slot_next       = idx_reg;
                rprof_next      = prof_reg;
                state_next      = S_RESP;
            end

            S_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.status  = status_reg;
    assign res.slot    = to_slot(slot_reg);
    assign res.profile = rprof_reg;
    assign res.indiv   = indiv_reg;
    assign res.group   = group_reg;

endmodule

// ===== rtl/core/entity_table_lookup_alloc.sv =====
// Entity table with lookup, lookup-or-insert, direct slot write and clear.
// Entries live in a 256-deep single-read-port memory, so lookup and allocate
// read the slots in turn. A miss or an insert reads every slot; a hit
// ends the scan early, so the lowest matching slot wins, and the lowest
// free slot is noted on the way. Write slot reads the old entry for the
// per-type counts, then writes the new one. One command is in work at a
// time; a finished result waits in the output register, so the next
// command beat is taken while the previous response beat is still stalled.
// depends on etl_pkg, etl_if, etl_store, etl_ctrl
module entity_table_lookup_alloc
    import etl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    etl_cmd_if.sink   cmd,
    etl_rsp_if.source rsp
);

    mem_req_t mem_req;
    mem_rsp_t mem_rsp;
    logic     res_valid;
    logic     res_ready;
    res_t     res;
    logic     rsp_valid_reg;
    res_t     rsp_data_reg;

    etl_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rsp   (mem_rsp)
    );

    etl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .mem_req   (mem_req),
        .mem_rsp   (mem_rsp),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register takes a result when empty or draining
    assign res_ready = !rsp_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_data_reg <= res;
        end
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.status           = rsp_data_reg.status;
    assign rsp.slot             = rsp_data_reg.slot;
    assign rsp.entry_profile    = rsp_data_reg.profile;
    assign rsp.individual_total = rsp_data_reg.indiv;
    assign rsp.group_total      = rsp_data_reg.group;

endmodule

// ===== rtl/core/etl_chk.sv =====
// port-level checks of the entity table, attached by bind
// depends on etl_pkg, entity_table_lookup_alloc_macros.svh
`include "entity_table_lookup_alloc_macros.svh"

module etl_chk
    import etl_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [2:0] status,
    input logic [7:0] slot,
    input logic [2:0] entry_profile,
    input logic [8:0] individual_total,
    input logic [8:0] group_total
);

    // a stalled response beat holds its payload
    `ETL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(slot) && $stable(entry_profile) && $stable(individual_total) && $stable(group_total), "response changed while stalled")

    // one command in work at a time
    `ETL_ASSERT_NEXT(a_one_cmd, cmd_valid && cmd_ready, !cmd_ready, "command taken while busy")

    // clear empties both counts and returns no slot
    `ETL_ASSERT_NOW(a_clear_zero, rsp_valid && status == ST_CLEARED, slot == 8'd0 && entry_profile == 3'd0 && individual_total == 9'd0 && group_total == 9'd0, "clear response not zero")

    // misses and rejects return no slot
    `ETL_ASSERT_NOW(a_miss_zero, rsp_valid && (status == ST_NOT_FOUND || status == ST_FULL || status == ST_BAD), slot == 8'd0 && entry_profile == 3'd0, "miss response carries a slot")

endmodule

bind entity_table_lookup_alloc etl_chk u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd.valid),
    .cmd_ready        (cmd.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .status           (rsp.status),
    .slot             (rsp.slot),
    .entry_profile    (rsp.entry_profile),
    .individual_total (rsp.individual_total),
    .group_total      (rsp.group_total)
);
